FILE: hdl/scp_pkg.sv
// Shared types, constants and helper functions of the sphere collision projector.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package scp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int RADIUS_W      = 31;
	localparam int CFG_IDX_W     = 2;
	localparam int ROOT_W        = 32;
	localparam int QUOT_W        = 33;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X = 2'd0,
		CFG_CENTER_Y = 2'd1,
		CFG_CENTER_Z = 2'd2,
		CFG_RADIUS   = 2'd3
	} cfg_index_t;

	// Item data that rides alongside the divider.
	typedef struct packed {
		logic [2:0][COORD_W-1:0] p;
		logic [2:0]              neg;
		logic                    hit;
		logic                    zero;
	} div_side_t;

	// Item data that rides alongside the square root.
	typedef struct packed {
		div_side_t         base;
		logic [2:0][63:0]  num;
	} sqrt_side_t;

	// Leading zero count of a 64-bit word (64 for zero).
	function automatic logic [6:0] lzc64(input logic [63:0] v);
		logic [6:0] n;
		n = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				n = 7'(63 - i);
			end
		end
		return n;
	endfunction

	// Clamp a 35-bit signed value to the 32-bit signed range.
	function automatic logic [COORD_W-1:0] sat32(input logic signed [34:0] v);
		logic [COORD_W-1:0] r;
		if (v > 35'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -35'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hdl/scp_sqrt_pipe.sv
// Fully pipelined integer square root: 64-bit radicand, 32-bit root, one bit per stage.
// Depends on scp_pkg. A sideband word travels with each transaction.
`timescale 1ns / 1ps

module scp_sqrt_pipe import scp_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [63:0]       radicand,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output logic [SIDE_W-1:0] side_out
);

	localparam int STEPS = ROOT_W;

	logic              valid_s [STEPS];
	logic [63:0]       rad_s   [STEPS];
	logic [33:0]       rem_s   [STEPS];
	logic [ROOT_W-1:0] root_s  [STEPS];
	logic [SIDE_W-1:0] side_s  [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int HI = 63 - 2 * k;
		logic              v_p;
		logic [63:0]       rad_p;
		logic [33:0]       rem_p;
		logic [ROOT_W-1:0] root_p;
		logic [SIDE_W-1:0] side_p;
		logic [33:0]       rem_n;
		logic [33:0]       trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_p    = in_valid;
			assign rad_p  = radicand;
			assign rem_p  = '0;
			assign root_p = '0;
			assign side_p = side_in;
		end else begin : g_next
			assign v_p    = valid_s[k-1];
			assign rad_p  = rad_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign side_p = side_s[k-1];
		end

		// Bring down the next bit pair and try to subtract 4*root + 1.
		assign rem_n = {rem_p[31:0], rad_p[HI:HI-1]};
		assign trial = {root_p, 2'b01};
		assign ge    = (rem_n >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_p;
				rem_s[k]  <= ge ? (rem_n - trial) : rem_n;
				root_s[k] <= {root_p[ROOT_W-2:0], ge};
				side_s[k] <= side_p;
			end
		end
	end

	assign out_valid = valid_s[STEPS-1];
	assign root      = root_s[STEPS-1];
	assign side_out  = side_s[STEPS-1];

endmodule

FILE: hdl/scp_div_pipe.sv
// Fully pipelined restoring divider: several 64-bit dividends over one shared 32-bit
// divisor, 33 quotient bits, one bit per stage. Depends on scp_pkg.
`timescale 1ns / 1ps

module scp_div_pipe import scp_pkg::*; #(
	parameter int LANES  = 3,
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [LANES-1:0][63:0]       dividend,
	input  logic [ROOT_W-1:0]            divisor,
	input  logic [SIDE_W-1:0]            side_in,
	output logic                         out_valid,
	output logic [LANES-1:0][QUOT_W-1:0] quotient,
	output logic [SIDE_W-1:0]            side_out
);

	localparam int STEPS = QUOT_W;

	logic                         valid_s [STEPS];
	logic [LANES-1:0][63:0]       num_s   [STEPS];
	logic [LANES-1:0][31:0]       rem_s   [STEPS];
	logic [LANES-1:0][QUOT_W-1:0] quot_s  [STEPS];
	logic [ROOT_W-1:0]            div_s   [STEPS];
	logic [SIDE_W-1:0]            side_s  [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int BIT = QUOT_W - 1 - k;
		logic                         v_p;
		logic [LANES-1:0][63:0]       num_p;
		logic [LANES-1:0][31:0]       rem_p;
		logic [LANES-1:0][QUOT_W-1:0] quot_p;
		logic [ROOT_W-1:0]            div_p;
		logic [SIDE_W-1:0]            side_p;
		logic [LANES-1:0][31:0]       rem_n;
		logic [LANES-1:0][QUOT_W-1:0] quot_n;

		if (k == 0) begin : g_first
			// The dividend bits above the quotient are known to stay below the divisor.
			assign v_p    = in_valid;
			assign num_p  = dividend;
			assign div_p  = divisor;
			assign side_p = side_in;
			assign quot_p = '0;
			for (genvar l = 0; l < LANES; l++) begin : g_init
				assign rem_p[l] = {1'b0, dividend[l][63:QUOT_W]};
			end
		end else begin : g_next
			assign v_p    = valid_s[k-1];
			assign num_p  = num_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign quot_p = quot_s[k-1];
			assign div_p  = div_s[k-1];
			assign side_p = side_s[k-1];
		end

		always_comb begin
			logic [32:0] r;
			logic        ge;
			for (int l = 0; l < LANES; l++) begin
				r  = {rem_p[l], num_p[l][BIT]};
				ge = (r >= {1'b0, div_p});
				rem_n[l]  = ge ? 32'(r - {1'b0, div_p}) : r[31:0];
				quot_n[l] = {quot_p[l][QUOT_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k]  <= num_p;
				rem_s[k]  <= rem_n;
				quot_s[k] <= quot_n;
				div_s[k]  <= div_p;
				side_s[k] <= side_p;
			end
		end
	end

	assign out_valid = valid_s[STEPS-1];
	assign quotient  = quot_s[STEPS-1];
	assign side_out  = side_s[STEPS-1];

endmodule

FILE: hdl/sphere_collision_projector.sv
// Top level of the sphere collision projector: stream ports, configuration registers,
// front-end stages and result stage. Depends on scp_pkg, scp_sqrt_pipe and scp_div_pipe.
`timescale 1ns / 1ps

// The block takes one cloth vertex per transaction and returns one corrected vertex per
// transaction, in order. It is a single pipeline of 70 register stages: four front-end
// stages (offset, squares and products, distance sum and compare, leading zero count),
// 32 square-root stages, 33 divider stages and the output register. A vertex can be
// accepted in every cycle while the pipeline moves, so the sustained rate is one
// transaction per clock while downstream keeps up. The whole pipeline advances
// together; it halts only while a result sits in the output register and the
// downstream side does not take it, and then s_tready drops. The radius is padded by
// 0.05 in the fixed-point format set by FRAC_BITS. A vertex strictly inside the padded
// sphere is moved onto its surface along the ray from the center, rounded to nearest;
// a vertex at the very center goes to the +x side. Results saturate to the signed
// 32-bit range. Configuration writes are registered, the squared padded radius one
// register later, and they should be made only while no transaction is in flight.

module sphere_collision_projector import scp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	// Vertex input stream.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [95:0]          s_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
	// Corrected vertex output stream.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [95:0]          m_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
	output logic                 m_tuser    // was_moved
);

	// The 0.05 margin rounded to nearest in the chosen format.
	localparam int MARGIN_I = ((1 << FRAC_BITS) + 10) / 20;
	localparam logic [31:0] MARGIN = 32'(MARGIN_I);

	localparam int SQ_SIDE_W  = $bits(sqrt_side_t);
	localparam int DIV_SIDE_W = $bits(div_side_t);

	// ---------------------------------------------------------------- configuration
	logic [2:0][COORD_W-1:0] cen_q;
	logic [RADIUS_W-1:0]     radius_q;
	logic [31:0]             rp;
	logic [63:0]             rp_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_q    <= '0;
			radius_q <= RADIUS_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_CENTER_X: cen_q[0] <= cfg_data;
				CFG_CENTER_Y: cen_q[1] <= cfg_data;
				CFG_CENTER_Z: cen_q[2] <= cfg_data;
				CFG_RADIUS:   radius_q <= cfg_data[RADIUS_W-1:0];
				default:      ;
			endcase
		end
	end

	// Padded radius; it always fits in 32 bits since the margin is far below 2^31.
	assign rp = {1'b0, radius_q} + MARGIN;

	always_ff @(posedge clk) begin
		rp_sq_q <= rp * rp;
	end

	// ---------------------------------------------------------------- flow control
	logic en;

	// The whole pipeline moves unless the output register holds an untaken result.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------------------------------------------------------- stage 1: offset
	logic                    valid_s1;
	logic [2:0][COORD_W-1:0] p_s1;
	logic [2:0][32:0]        d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= s_tdata[i*COORD_W +: COORD_W];
				d_s1[i] <= {s_tdata[i*COORD_W + COORD_W - 1], s_tdata[i*COORD_W +: COORD_W]}
				         - {cen_q[i][COORD_W-1], cen_q[i]};
			end
		end
	end

	// ---------------------------------------------------------------- stage 2: products
	logic [2:0][32:0]        a_c;
	logic                    far_c;
	logic                    valid_s2;
	logic [2:0][COORD_W-1:0] p_s2;
	logic [2:0]              neg_s2;
	logic                    far_s2;
	logic [2:0][63:0]        sq_s2;
	logic [2:0][63:0]        pr_s2;

	always_comb begin
		far_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a_c[i] = d_s1[i][32] ? (33'd0 - d_s1[i]) : d_s1[i];
			if (a_c[i] >= {1'b0, rp}) begin
				far_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	// When no axis is far, every |d| is below rp and fits in 32 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2   <= p_s1;
			far_s2 <= far_c;
			for (int i = 0; i < 3; i++) begin
				neg_s2[i] <= d_s1[i][32];
				sq_s2[i]  <= a_c[i][31:0] * a_c[i][31:0];
				pr_s2[i]  <= rp * a_c[i][31:0];
			end
		end
	end

	// ---------------------------------------------------------------- stage 3: compare
	logic [65:0]             dist_c;
	logic                    inside_c;
	logic                    valid_s3;
	logic [2:0][COORD_W-1:0] p_s3;
	logic [2:0]              neg_s3;
	logic                    inside_s3;
	logic                    zero_s3;
	logic [63:0]             dist_s3;
	logic [2:0][63:0]        pr_s3;

	assign dist_c   = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};
	assign inside_c = !far_s2 && (dist_c < {2'b00, rp_sq_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3      <= p_s2;
			neg_s3    <= neg_s2;
			inside_s3 <= inside_c;
			zero_s3   <= (dist_c == 66'd0);
			dist_s3   <= dist_c[63:0];
			pr_s3     <= pr_s2;
		end
	end

	// ---------------------------------------------------------------- stage 4: normalize count
	logic [6:0]              lz_c;
	logic                    valid_s4;
	logic [2:0][COORD_W-1:0] p_s4;
	logic [2:0]              neg_s4;
	logic                    inside_s4;
	logic                    zero_s4;
	logic [63:0]             dist_s4;
	logic [2:0][63:0]        pr_s4;
	logic [4:0]              h_s4;

	assign lz_c = lzc64(dist_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	// Half the leading zero count gives the even shift that puts the top pair at 62..63.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s4      <= p_s3;
			neg_s4    <= neg_s3;
			inside_s4 <= inside_s3;
			zero_s4   <= zero_s3;
			dist_s4   <= dist_s3;
			pr_s4     <= pr_s3;
			h_s4      <= lz_c[5:1];
		end
	end

	// ---------------------------------------------------------------- shift into the root
	logic [63:0] norm_c;
	sqrt_side_t  sq_side_in;
	sqrt_side_t  sq_side_out;
	logic        sq_valid;
	logic [31:0] root;

	assign norm_c = dist_s4 << {h_s4, 1'b0};

	always_comb begin
		sq_side_in.base.p    = p_s4;
		sq_side_in.base.neg  = neg_s4;
		sq_side_in.base.hit  = inside_s4;
		sq_side_in.base.zero = zero_s4;
		for (int i = 0; i < 3; i++) begin
			sq_side_in.num[i] = pr_s4[i] << h_s4;
		end
	end

	scp_sqrt_pipe #(
		.SIDE_W (SQ_SIDE_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.radicand  (norm_c),
		.side_in   (sq_side_in),
		.out_valid (sq_valid),
		.root      (root),
		.side_out  (sq_side_out)
	);

	// ---------------------------------------------------------------- divide
	logic [2:0][63:0]        dvd_c;
	logic                    dv_valid;
	logic [2:0][QUOT_W-1:0]  quot;
	div_side_t               dv_side_out;

	// Adding half the divisor turns the truncating quotient into round to nearest.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dvd_c[i] = sq_side_out.num[i] + {33'd0, root[31:1]};
		end
	end

	scp_div_pipe #(
		.LANES  (3),
		.SIDE_W (DIV_SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.dividend  (dvd_c),
		.divisor   (root),
		.side_in   (sq_side_out.base),
		.out_valid (dv_valid),
		.quotient  (quot),
		.side_out  (dv_side_out)
	);

	// ---------------------------------------------------------------- result stage
	logic [2:0][COORD_W-1:0] res_c;
	logic                    moved_c;
	logic [95:0]             data_q;
	logic                    moved_q;
	logic                    valid_q;

	always_comb begin
		logic signed [34:0] base;
		logic signed [34:0] step;
		moved_c = dv_side_out.hit;
		for (int i = 0; i < 3; i++) begin
			base = 35'({{3{cen_q[i][COORD_W-1]}}, cen_q[i]});
			step = 35'({2'b00, quot[i]});
			if (!dv_side_out.hit) begin
				res_c[i] = dv_side_out.p[i];
			end else if (dv_side_out.zero) begin
				// A vertex at the center is pushed out along +x.
				res_c[i] = (i == 0) ? sat32(base + 35'({3'b000, rp})) : cen_q[i];
			end else begin
				res_c[i] = dv_side_out.neg[i] ? sat32(base - step) : sat32(base + step);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q  <= res_c;
			moved_q <= moved_c;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = moved_q;

	// ---------------------------------------------------------------- checks
	// An inside distance is below rp^2, so it never needs more than 64 bits.
	a_dist_fits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && inside_c |-> dist_c[65:64] == 2'b00)
		else $error("inside distance exceeds 64 bits");

	// Normalization must leave the top bit pair of a nonzero inside distance set.
	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && inside_s4 && !zero_s4 |-> norm_c[63:62] != 2'b00)
		else $error("normalized distance lost its top bits");

	// The root of a normalized radicand has its top bit set, so the divider sees L >= 2^31.
	a_root_msb: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid && sq_side_out.base.hit && !sq_side_out.base.zero |-> root[31])
		else $error("square root below 2^31 for a normalized radicand");

endmodule

FILE: tb/sv/sphere_collision_projector_chk.sv
// Checker of the sphere collision projector: watches the configuration port and both streams,
// predicts each corrected vertex and compares it with what the block returns. Depends on scp_pkg.
`timescale 1ns / 1ps

module sphere_collision_projector_chk import scp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [95:0]          s_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [95:0]          m_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
	input  logic                 m_tuser,   // was_moved
	output int                   fails,
	output int                   pending
);

	localparam longint MARGIN = ((64'd1 << FRAC_BITS_DEF) + 10) / 20;

	longint        center [3];
	bit [30:0]     radius;
	logic [96:0]   corrected_q [$];

	function automatic bit [63:0] root64(input bit [63:0] v);
		bit [63:0] r;
		bit [63:0] b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Returns {was_moved, z, y, x}.
	function automatic logic [96:0] project_vertex(input logic [95:0] pt);
		longint    p [3];
		longint    d [3];
		bit [63:0] a [3];
		bit [31:0] o [3];
		bit [63:0] rp, s, t, l, num, m;
		int        h;
		bit        far;
		rp  = 64'(radius) + MARGIN;
		far = 0;
		s   = 0;
		for (int i = 0; i < 3; i++) begin
			p[i] = longint'($signed(pt[32*i +: 32]));
			d[i] = p[i] - center[i];
			a[i] = (d[i] < 0) ? -d[i] : d[i];
			if (a[i] >= rp) far = 1;
		end
		if (!far) for (int i = 0; i < 3; i++) s += a[i] * a[i];
		if (far || s >= rp * rp) return {1'b0, pt};
		// A vertex sitting on the center is pushed out along +x.
		if (s == 0)
			return {1'b1, clamp32(center[2]), clamp32(center[1]),
				clamp32(center[0] + longint'(rp))};
		t = s;
		h = 0;
		while (t < (64'd1 << 62)) begin
			t <<= 2;
			h++;
		end
		l = root64(t);
		for (int i = 0; i < 3; i++) begin
			num  = (rp * a[i]) << h;
			m    = (num + (l >> 1)) / l;
			o[i] = clamp32(d[i] < 0 ? center[i] - longint'(m) : center[i] + longint'(m));
		end
		return {1'b1, o[2], o[1], o[0]};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	assign pending = corrected_q.size();

	initial fails = 0;

	always @(posedge clk or negedge arst_n) begin
		logic [96:0] want;
		if (!arst_n) begin
			center[0] = 0;
			center[1] = 0;
			center[2] = 0;
			radius    = 31'd65536;
			corrected_q.delete();
		end else begin
			if (s_tvalid && s_tready) corrected_q.push_back(project_vertex(s_tdata));
			if (m_tvalid && m_tready) begin
				if (corrected_q.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata[31:0], 32'h0);
				end else begin
					want = corrected_q.pop_front();
					if (m_tdata[31:0] !== want[31:0])
						report_mismatch("out_x", m_tdata[31:0], want[31:0]);
					if (m_tdata[63:32] !== want[63:32])
						report_mismatch("out_y", m_tdata[63:32], want[63:32]);
					if (m_tdata[95:64] !== want[95:64])
						report_mismatch("out_z", m_tdata[95:64], want[95:64]);
					if (m_tuser !== want[96])
						report_mismatch("was_moved", 32'(m_tuser), 32'(want[96]));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_CENTER_X: center[0] = longint'($signed(cfg_data));
					CFG_CENTER_Y: center[1] = longint'($signed(cfg_data));
					CFG_CENTER_Z: center[2] = longint'($signed(cfg_data));
					CFG_RADIUS:   radius    = cfg_data[30:0];
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: tb/sv/sphere_collision_projector_tb.sv
// Top of the sphere collision projector testbench: clock, reset, stimulus and verdict.
// Depends on scp_pkg, sphere_collision_projector and sphere_collision_projector_chk.
`timescale 1ns / 1ps

// The sender walks through several sphere settings, writing each new one on an idle block,
// and streams vertices: short directed sets and random ones that mostly land near the
// padded sphere so both the pass-through and projection paths are exercised, with some
// fully random coordinates mixed in. Both sides insert random gaps, but for one stall-free
// run. All inputs change on the falling edge; the checker samples on the rising edge,
// so no result depends on event ordering inside a time step.

module sphere_collision_projector_tb import scp_pkg::*;;

	localparam int     LIMIT  = 400000;
	localparam longint MARGIN = ((64'd1 << FRAC_BITS_DEF) + 10) / 20;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CENTER_X;
	logic [COORD_W-1:0]   cfg_data = 0;
	logic                 s_tvalid = 0;
	logic                 s_tready;
	logic [95:0]          s_tdata = 0;
	logic                 m_tvalid;
	logic                 m_tready = 0;
	logic [95:0]          m_tdata;
	logic                 m_tuser;
	int                   fails;
	int                   pending;
	int                   cycles = 0;
	bit                   stall_free = 0;

	// The software copy of the sphere that the stimulus aims at.
	longint cen [3];
	longint rad;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	sphere_collision_projector u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	sphere_collision_projector_chk u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fails(fails), .pending(pending)
	);

	// The run is cut off if it stalls far beyond any plausible correct schedule.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int gap_len();
		if (stall_free) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	// The receiver holds tready low for random stretches.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = gap_len();
			if (n > 0) begin
				m_tready = 0;
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready = 1;
			end
		end
	end

	task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z);
		int n;
		n = gap_len();
		if (n > 0) begin
			s_tvalid = 0;
			repeat (n) @(negedge clk);
		end
		s_tvalid = 1;
		s_tdata  = {z, y, x};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 0;
	endtask

	// Sends a vertex at a given offset from the current center.
	task automatic send_offset(input longint dx, input longint dy, input longint dz);
		longint x, y, z;
		x = cen[0] + dx;
		y = cen[1] + dy;
		z = cen[2] + dz;
		send_vertex(x[31:0], y[31:0], z[31:0]);
	endtask

	task automatic wait_idle();
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
		cfg_we    = 1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 0;
		case (idx)
			CFG_CENTER_X: cen[0] = longint'($signed(val));
			CFG_CENTER_Y: cen[1] = longint'($signed(val));
			CFG_CENTER_Z: cen[2] = longint'($signed(val));
			default:      rad    = longint'(val[30:0]);
		endcase
	endtask

	task automatic set_sphere(input logic [31:0] cx, input logic [31:0] cy,
		input logic [31:0] cz, input logic [31:0] r);
		wait_idle();
		write_reg(CFG_CENTER_X, cx);
		write_reg(CFG_CENTER_Y, cy);
		write_reg(CFG_CENTER_Z, cz);
		write_reg(CFG_RADIUS, r);
	endtask

	// Random vertices: most sit within about 1.3 padded radii of the center on each axis.
	task automatic random_vertices(input int count);
		longint span, off [3];
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 7) == 0) begin
				send_vertex($urandom, $urandom, $urandom);
			end else begin
				span = ((rad + MARGIN) * 13) / 10 + 1;
				for (int i = 0; i < 3; i++)
					off[i] = longint'($urandom_range(0, 32'hFFFF_FFFF)) % (2 * span + 1) - span;
				send_offset(off[0], off[1], off[2]);
			end
		end
	endtask

	initial begin
		longint rp;
		cen[0] = 0;
		cen[1] = 0;
		cen[2] = 0;
		rad    = 65536;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Reset settings: unit sphere at the origin.
		rp = rad + MARGIN;
		send_offset(0, 0, 0);                 // vertex on the center
		send_offset(rp, 0, 0);                // exactly one padded radius away
		send_offset(rp - 1, 0, 0);
		send_offset(-(rp - 1), 0, 0);
		send_offset(0, -1000, 2000);
		send_offset(-100, 0, -(rp - 1));
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vertex(32'hFFFF_FFFF, 32'h0, 32'h1);
		send_vertex(32'h0, 32'h0, 32'h0);

		// Padded radius of exactly 100000 makes a 3-4-5 offset land on the surface.
		set_sphere(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'(100000 - MARGIN));
		send_offset(60000, 80000, 0);
		send_offset(59999, 80000, 0);
		send_offset(0, -60000, -80000);
		send_offset(-40000, 30000, 0);
		random_vertices(100);

		// Zero radius, center at the positive corner: projections saturate.
		set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
		send_offset(0, 0, 0);
		send_offset(-100, -200, 0);
		send_offset(1000, 0, 0);
		random_vertices(100);

		// Largest radius, center at the negative corner.
		set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_offset(0, 0, 0);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		send_vertex(32'h0, 32'h0, 32'h0);
		send_vertex(32'h8000_0001, 32'h8000_0000, 32'hC000_0000);
		random_vertices(150);

		// Largest radius at the origin: wide distances and big products.
		set_sphere(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
		random_vertices(150);

		// Hold the sender off until the pipeline has fully drained once.
		while (pending != 0) @(negedge clk);
		stall_free = 1;
		random_vertices(150);
		stall_free = 0;

		// A run of random spheres.
		for (int ph = 0; ph < 6; ph++) begin
			set_sphere($urandom, $urandom, $urandom,
				($urandom_range(0, 1) == 0) ? $urandom_range(0, 32'h0010_0000) : $urandom);
			random_vertices(100);
		end

		wait_idle();
		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
